// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/core/fmfs_pkg.sv -----
// Package for fourier_mode_field_synthesis: payload types, constants, cosine.
// No dependencies.
package fmfs_pkg;
    localparam int MAX_MODES = 256;
    localparam int IDX_W = $clog2(MAX_MODES);
    localparam int CNT_W = $clog2(MAX_MODES + 1);
    localparam int CFG_W = 24;
    localparam int MODE_W = 24 * 3 + 32 * 3 + 16;
    localparam int QDEPTH = 2;

    localparam logic [0:0] CMD_LOAD  = 1'b0;
    localparam logic [0:0] CMD_QUERY = 1'b1;
    localparam logic [0:0] REG_MODE_COUNT = 1'b0;
    localparam logic [0:0] REG_BACKGROUND = 1'b1;

    localparam logic signed [31:0] COS_C1 = 32'sd1324675879;
    localparam logic signed [31:0] COS_C2 = 32'sd272375560;
    localparam logic signed [31:0] COS_C3 = 32'sd22401992;
    localparam logic signed [31:0] COS_C4 = 32'sd987048;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    typedef struct packed {
        logic [0:0]         cmd;
        logic [7:0]         mode_index;
        logic signed [23:0] amp_x;
        logic signed [23:0] amp_y;
        logic signed [23:0] amp_z;
        logic signed [31:0] wave_x;
        logic signed [31:0] wave_y;
        logic signed [31:0] wave_z;
        logic [15:0]        phase_offset;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
    } t_out;

    typedef struct packed {
        logic signed [23:0] amp_x;
        logic signed [23:0] amp_y;
        logic signed [23:0] amp_z;
        logic signed [31:0] wave_x;
        logic signed [31:0] wave_y;
        logic signed [31:0] wave_z;
        logic [15:0]        phase;
    } t_mode;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_query;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DOT, S_SUM, S_PH, S_POLY, S_COS, S_SCALE, S_ACC, S_BG, S_OUT
    } t_state;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction
endpackage

// ----- rtl/core/fmfs_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
module fmfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/fmfs_front.sv -----
// Front end: accepts items, writes loads to the mode RAM, queues queries.
// Depends on fmfs_pkg, fmfs_ram.
module fmfs_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  fmfs_pkg::t_in            i_data,
    input  logic [fmfs_pkg::IDX_W-1:0] i_raddr,
    output fmfs_pkg::t_mode          o_mode,
    output logic                     o_q_valid,
    output fmfs_pkg::t_query         o_q_data,
    input  logic                     i_q_pop,
    input  logic                     i_busy
);
    fmfs_pkg::t_query r_q [fmfs_pkg::QDEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic accept, push, we;
    fmfs_pkg::t_mode wmode;

    // hold loads until every earlier query has finished its walk
    assign o_stall = (r_cnt == 2'(fmfs_pkg::QDEPTH))
        || ((i_data.cmd == fmfs_pkg::CMD_LOAD) && ((r_cnt != 2'd0) || i_busy));
    assign accept = i_valid && !o_stall;
    assign push = accept && (i_data.cmd == fmfs_pkg::CMD_QUERY);
    assign we = accept && (i_data.cmd == fmfs_pkg::CMD_LOAD)
        && ({1'b0, i_data.mode_index} < 9'(fmfs_pkg::MAX_MODES));
    assign wmode = '{i_data.amp_x, i_data.amp_y, i_data.amp_z,
        i_data.wave_x, i_data.wave_y, i_data.wave_z, i_data.phase_offset};
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_q[r_rp];

    fmfs_ram #(.WIDTH(fmfs_pkg::MODE_W), .DEPTH(fmfs_pkg::MAX_MODES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(i_data.mode_index[fmfs_pkg::IDX_W-1:0]),
        .i_wdata(wmode), .i_raddr(i_raddr), .o_rdata(o_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= '{i_data.pos_x, i_data.pos_y, i_data.pos_z};
    end
endmodule

// ----- rtl/core/fmfs_back.sv -----
// Back end: walks the mode table for one query, sums cosine-scaled amplitudes.
// Depends on fmfs_pkg.
module fmfs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [8:0]                 i_mode_count,
    input  logic signed [23:0]         i_background,
    input  logic                       i_q_valid,
    input  fmfs_pkg::t_query           i_q_data,
    output logic                       o_q_pop,
    output logic                       o_busy,
    output logic [fmfs_pkg::IDX_W-1:0] o_raddr,
    input  fmfs_pkg::t_mode            i_mode,
    output logic                       o_valid,
    input  logic                       i_stall,
    output fmfs_pkg::t_out             o_data
);
    fmfs_pkg::t_state r_st, n_st;
    fmfs_pkg::t_query r_pos;
    fmfs_pkg::t_mode r_m;
    logic [fmfs_pkg::CNT_W-1:0] r_i, r_n;
    logic signed [63:0] r_px, r_py, r_pz, r_c;
    logic [15:0] r_ph;
    logic signed [63:0] r_s, r_r;
    logic [2:0] r_k;
    logic signed [63:0] r_sx, r_sy, r_sz, r_fx, r_fy, r_fz;
    logic r_ovalid;
    fmfs_pkg::t_out r_out;
    logic [fmfs_pkg::CNT_W-1:0] cnt;
    logic signed [63:0] prod, coef, x, nr, cq;
    logic [14:0] tq;
    logic [1:0] quad;

    assign cnt = (i_mode_count > 9'(fmfs_pkg::MAX_MODES))
        ? fmfs_pkg::CNT_W'(fmfs_pkg::MAX_MODES) : fmfs_pkg::CNT_W'(i_mode_count);
    assign o_raddr = r_i[fmfs_pkg::IDX_W-1:0];
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign quad = r_ph[15:14];
    assign tq = (quad[0]) ? 15'(15'd16384 - {1'b0, r_ph[13:0]}) : {1'b0, r_ph[13:0]};
    assign x = 64'(tq) <<< 16;

    always_comb begin
        case (r_k)
            3'd1: coef = 64'(fmfs_pkg::COS_C3);
            3'd2: coef = 64'(fmfs_pkg::COS_C2);
            3'd3: coef = 64'(fmfs_pkg::COS_C1);
            default: coef = 64'(fmfs_pkg::ONE_Q30);
        endcase
        prod = (r_r * r_s) >>> 30;
        nr = coef - prod;
    end

    always_comb begin
        if (r_r < 0) cq = 64'sd0;
        else if (r_r > 64'(fmfs_pkg::ONE_Q30)) cq = 64'(fmfs_pkg::ONE_Q30);
        else cq = r_r;
        cq = (cq + 64'sd16384) >>> 15;
        if (cq > 64'sd32767) cq = 64'sd32767;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            fmfs_pkg::S_IDLE: if (i_q_valid) n_st = (cnt == '0) ? fmfs_pkg::S_BG
                                                   : fmfs_pkg::S_READ;
            fmfs_pkg::S_READ: n_st = fmfs_pkg::S_DOT;
            fmfs_pkg::S_DOT: n_st = fmfs_pkg::S_SUM;
            fmfs_pkg::S_SUM: n_st = fmfs_pkg::S_PH;
            fmfs_pkg::S_PH: n_st = fmfs_pkg::S_POLY;
            fmfs_pkg::S_POLY: if (r_k == 3'd4) n_st = fmfs_pkg::S_COS;
            fmfs_pkg::S_COS: n_st = fmfs_pkg::S_SCALE;
            fmfs_pkg::S_SCALE: n_st = fmfs_pkg::S_ACC;
            fmfs_pkg::S_ACC: n_st = (r_i == r_n) ? fmfs_pkg::S_BG : fmfs_pkg::S_READ;
            fmfs_pkg::S_BG: n_st = fmfs_pkg::S_OUT;
            fmfs_pkg::S_OUT: if (!r_ovalid || !i_stall) n_st = fmfs_pkg::S_IDLE;
            default: n_st = fmfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == fmfs_pkg::S_IDLE) && i_q_valid;
        o_busy = (r_st != fmfs_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fmfs_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (r_st == fmfs_pkg::S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            fmfs_pkg::S_IDLE: begin
                r_pos <= i_q_data;
                r_n <= cnt;
                r_i <= '0;
                r_fx <= '0;
                r_fy <= '0;
                r_fz <= '0;
            end
            fmfs_pkg::S_READ: r_i <= r_i + 1'b1;
            fmfs_pkg::S_DOT: begin
                r_m <= i_mode;
                r_px <= 64'(i_mode.wave_x) * 64'(r_pos.pos_x);
                r_py <= 64'(i_mode.wave_y) * 64'(r_pos.pos_y);
                r_pz <= 64'(i_mode.wave_z) * 64'(r_pos.pos_z);
            end
            fmfs_pkg::S_SUM: r_px <= r_px + r_py + r_pz;
            fmfs_pkg::S_PH: begin
                r_ph <= r_px[39:24] + r_m.phase;
                r_k <= '0;
            end
            fmfs_pkg::S_POLY: begin
                if (r_k == 3'd0) begin
                    r_s <= (x * x) >>> 30;
                    r_r <= 64'(fmfs_pkg::COS_C4);
                end else r_r <= nr;
                r_k <= r_k + 3'd1;
            end
            fmfs_pkg::S_COS: r_c <= (quad == 2'd1 || quad == 2'd2) ? -cq : cq;
            fmfs_pkg::S_SCALE: begin
                r_sx <= (64'(r_m.amp_x) * r_c + 64'sd16384) >>> 15;
                r_sy <= (64'(r_m.amp_y) * r_c + 64'sd16384) >>> 15;
                r_sz <= (64'(r_m.amp_z) * r_c + 64'sd16384) >>> 15;
            end
            fmfs_pkg::S_ACC: begin
                r_fx <= fmfs_pkg::sat32(r_fx + r_sx);
                r_fy <= fmfs_pkg::sat32(r_fy + r_sy);
                r_fz <= fmfs_pkg::sat32(r_fz + r_sz);
            end
            fmfs_pkg::S_BG: r_fz <= fmfs_pkg::sat32(r_fz + 64'(i_background));
            fmfs_pkg::S_OUT: if (!r_ovalid || !i_stall)
                r_out <= '{r_fx[31:0], r_fy[31:0], r_fz[31:0]};
            default: ;
        endcase
    end
endmodule

// ----- rtl/core/fourier_mode_field_synthesis.sv -----
// Fourier-mode field synthesis: mode table, query walk, saturating sum.
// A load is accepted once no query is queued or being summed; a query is
// popped, then summed over the modes in use by the shared dot-product, cosine
// polynomial and accumulate unit that walks the mode RAM one entry at a time,
// and then the background is added to field_z and the result is output.
// Two queries may wait in the queue while one is summed. Depends on fmfs_pkg.
module fourier_mode_field_synthesis (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  fmfs_pkg::t_in           i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output fmfs_pkg::t_out          o_data,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [fmfs_pkg::CFG_W-1:0] i_cfg_data
);
    logic [8:0] r_mode_count;
    logic signed [23:0] r_background;
    logic q_valid, q_pop, busy;
    fmfs_pkg::t_query q_data;
    fmfs_pkg::t_mode mode;
    logic [fmfs_pkg::IDX_W-1:0] raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_count <= '0;
            r_background <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fmfs_pkg::REG_MODE_COUNT: r_mode_count <= i_cfg_data[8:0];
                fmfs_pkg::REG_BACKGROUND: r_background <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fmfs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .i_raddr(raddr), .o_mode(mode),
        .o_q_valid(q_valid), .o_q_data(q_data), .i_q_pop(q_pop), .i_busy(busy)
    );

    fmfs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mode_count(r_mode_count),
        .i_background(r_background), .i_q_valid(q_valid), .i_q_data(q_data),
        .o_q_pop(q_pop), .o_busy(busy), .o_raddr(raddr), .i_mode(mode),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule

// ----- rtl/core/fmfs_checker.sv -----
// Port checker for fourier_mode_field_synthesis, bound to the top level.
// Depends on fmfs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fmfs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input fmfs_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input fmfs_pkg::t_out o_data
);
    logic in_wait, out_wait, load_acc;

    assign in_wait = i_valid && o_stall;
    assign out_wait = o_valid && i_stall;
    assign load_acc = i_valid && !o_stall && (i_data.cmd == fmfs_pkg::CMD_LOAD) && !o_valid;

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_valid && $stable(o_data), "out")
    `CHK_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_valid && $stable(i_data), "in")
    `CHK_NEXT(a_load_nostall, i_clk, i_rst_n, load_acc, !o_valid, "load")
endmodule

bind fourier_mode_field_synthesis fmfs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
